// ----- hdl/bfa_pkg.sv -----
// bfa_pkg: shared types, codes and helpers of the best-fit page chunk allocator
// used by bfa_cell and best_fit_page_chunk_allocator; depends on nothing else

package bfa_pkg;

  // fixed field widths of the transaction payloads
  localparam int unsigned PAGE_W  = 44;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned TOTAL_W = 44;

  // default geometry
  localparam int unsigned MAX_CHUNKS_DEF       = 64;
  localparam int unsigned PAGE_NUMBER_BITS_DEF = 44;

  // request codes
  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bfa_cmd_e;

  // result codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_IGNORED = 2'd2,
    ST_FULL    = 2'd3
  } bfa_status_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_POOL_BASE  = 1'b0,
    REG_POOL_COUNT = 1'b1
  } bfa_reg_e;

  // operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_PUSH   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SPLIT  = 3'd3,
    OP_LOAD   = 3'd4
  } bfa_op_e;

  typedef struct packed {
    bfa_cmd_e             command;
    logic [PAGE_W-1:0]    page_number;
    logic [COUNT_W-1:0]   page_count;
  } bfa_in_t;

  typedef struct packed {
    bfa_status_e          status;
    logic [PAGE_W-1:0]    granted_page;
    logic [TOTAL_W-1:0]   free_total;
  } bfa_out_t;

  // one list entry
  typedef struct packed {
    logic                 valid;
    logic [PAGE_W-1:0]    base;
    logic [PAGE_W-1:0]    size;
  } bfa_chunk_t;

  // control broadcast to the cells
  typedef struct packed {
    bfa_op_e              op;
    logic [COUNT_W-1:0]   cnt;
    bfa_chunk_t           head;
  } bfa_ctl_t;

  // best candidate so far, handed down the chain
  typedef struct packed {
    logic                 found;
    logic [PAGE_W-1:0]    base;
    logic [PAGE_W-1:0]    size;
  } bfa_best_t;

  // mask of the implemented page number bits
  function automatic logic [PAGE_W-1:0] page_mask(input int unsigned bits);
    logic [63:0] m;
    m = (64'd1 << bits) - 64'd1;
    if (bits >= PAGE_W) begin
      return '1;
    end
    return m[PAGE_W-1:0];
  endfunction

endpackage

// ----- hdl/bfa_cell.sv -----
// bfa_cell: one entry of the free chunk list plus its stage of the best-fit scan
// depends on bfa_pkg; instantiated in a row by best_fit_page_chunk_allocator

module bfa_cell #(
  parameter int unsigned IDX_W            = 6,
  parameter int unsigned CELL_IDX         = 0,
  parameter int unsigned PAGE_NUMBER_BITS = bfa_pkg::PAGE_NUMBER_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfa_pkg::bfa_ctl_t   ctl_i,
  input  logic [IDX_W-1:0]    pick_i,
  input  bfa_pkg::bfa_chunk_t left_i,
  input  bfa_pkg::bfa_chunk_t right_i,
  output bfa_pkg::bfa_chunk_t chunk_o,
  input  bfa_pkg::bfa_best_t  best_i,
  input  logic [IDX_W-1:0]    best_idx_i,
  output bfa_pkg::bfa_best_t  best_o,
  output logic [IDX_W-1:0]    best_idx_o
);

  localparam logic [bfa_pkg::PAGE_W-1:0] PageMask = bfa_pkg::page_mask(PAGE_NUMBER_BITS);
  localparam logic [IDX_W-1:0]           MyIdx    = IDX_W'(CELL_IDX);

  bfa_pkg::bfa_chunk_t chunk_q, chunk_d;
  bfa_pkg::bfa_best_t  best_q, best_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic [bfa_pkg::PAGE_W-1:0] cnt_ext;
  logic                take;

  assign cnt_ext = bfa_pkg::PAGE_W'(ctl_i.cnt);

  // entry update: shift from a neighbor, split in place or reload
  always_comb begin
    chunk_d = chunk_q;
    unique case (ctl_i.op)
      bfa_pkg::OP_HOLD: begin
      end
      bfa_pkg::OP_PUSH: begin
        chunk_d = left_i;
      end
      bfa_pkg::OP_REMOVE: begin
        if (MyIdx >= pick_i) begin
          chunk_d = right_i;
        end
      end
      bfa_pkg::OP_SPLIT: begin
        if (MyIdx == pick_i) begin
          chunk_d.base = (chunk_q.base + cnt_ext) & PageMask;
          chunk_d.size = chunk_q.size - cnt_ext;
        end
      end
      bfa_pkg::OP_LOAD: begin
        if (CELL_IDX == 0) begin
          chunk_d = left_i;
        end else begin
          chunk_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // scan stage: keep the earlier candidate unless this one is strictly smaller
  assign take = chunk_q.valid && (chunk_q.size >= cnt_ext) &&
                (!best_i.found || (chunk_q.size < best_i.size));

  always_comb begin
    best_d     = best_i;
    best_idx_d = best_idx_i;
    if (take) begin
      best_d.found = 1'b1;
      best_d.base  = chunk_q.base;
      best_d.size  = chunk_q.size;
      best_idx_d   = MyIdx;
    end
  end

  // list entry and scan token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q    <= '0;
      best_q     <= '0;
      best_idx_q <= '0;
    end else begin
      chunk_q    <= chunk_d;
      best_q     <= best_d;
      best_idx_q <= best_idx_d;
    end
  end

  assign chunk_o    = chunk_q;
  assign best_o     = best_q;
  assign best_idx_o = best_idx_q;

endmodule

// ----- hdl/best_fit_page_chunk_allocator.sv -----
// best_fit_page_chunk_allocator: best-fit free list of physical page chunks
// depends on bfa_pkg and bfa_cell
//
// Usage: requests come in on in_valid_i/in_ready_o with a bfa_in_t payload
// (allocate or free), one result per request leaves on out_valid_o/out_ready_i
// as a bfa_out_t. The list lives in a row of MAX_CHUNKS cells, one entry each.
// An allocate runs a scan token down the row, one cell per cycle, then passes
// through S_APPLY and S_DONE before its result is registered. A free, an ignored
// request or a full-table drop goes from S_IDLE straight to S_DONE. One request
// is in flight at a time; in_ready_o is high while the block waits for a request,
// also while an earlier result is still held in the output register. If the
// receiver stalls, the next result waits until the held one is taken, and input
// stays blocked meanwhile.
// Configuration: cfg_we_i writes register cfg_idx_i (0 pool base, 1 pool page
// count); writing the count reloads the list as one chunk, or empty for zero.
// Write only while no request is in flight.
// Reset: the list is empty, both registers and the free total are zero; the
// block accepts a request in the first cycle after reset.

module best_fit_page_chunk_allocator #(
  parameter int unsigned MAX_CHUNKS       = bfa_pkg::MAX_CHUNKS_DEF,
  parameter int unsigned PAGE_NUMBER_BITS = bfa_pkg::PAGE_NUMBER_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bfa_pkg::bfa_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bfa_pkg::bfa_out_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [bfa_pkg::PAGE_W-1:0]  cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(MAX_CHUNKS);
  localparam logic [bfa_pkg::PAGE_W-1:0] PageMask = bfa_pkg::page_mask(PAGE_NUMBER_BITS);
  localparam int unsigned FreeW = bfa_pkg::TOTAL_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_DONE
  } state_e;

  state_e                         state_q;
  logic [IdxW-1:0]                scan_cnt_q;
  logic [bfa_pkg::COUNT_W-1:0]    cnt_q;
  bfa_pkg::bfa_status_e           status_q;
  logic [bfa_pkg::PAGE_W-1:0]     granted_q;
  logic [FreeW-1:0]               pages_free_q;
  logic [bfa_pkg::PAGE_W-1:0]     pool_base_q;
  logic                           out_valid_q;
  bfa_pkg::bfa_out_t              out_data_q;

  bfa_pkg::bfa_ctl_t              ctl;
  bfa_pkg::bfa_chunk_t            chunk_w [MAX_CHUNKS];
  bfa_pkg::bfa_best_t             best_w [MAX_CHUNKS];
  logic [IdxW-1:0]                best_idx_w [MAX_CHUNKS];

  logic [bfa_pkg::PAGE_W-1:0]     page_m;
  logic                           req_ignored;
  logic                           list_full;
  bfa_pkg::bfa_best_t             best_end;
  logic [IdxW-1:0]                best_idx_end;

  assign page_m       = in_data_i.page_number & PageMask;
  assign req_ignored  = (in_data_i.page_count == '0) ||
                        ((in_data_i.command == bfa_pkg::CMD_FREE) && (page_m == '0));
  assign list_full    = chunk_w[MAX_CHUNKS-1].valid;
  assign best_end     = best_w[MAX_CHUNKS-1];
  assign best_idx_end = best_idx_w[MAX_CHUNKS-1];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // operation broadcast to the row
  always_comb begin
    ctl      = '0;
    ctl.op   = bfa_pkg::OP_HOLD;
    ctl.cnt  = cnt_q;
    if (cfg_we_i && (cfg_idx_i == bfa_pkg::REG_POOL_COUNT)) begin
      ctl.op         = bfa_pkg::OP_LOAD;
      ctl.head.valid = (cfg_wdata_i != '0);
      ctl.head.base  = pool_base_q;
      ctl.head.size  = cfg_wdata_i;
    end else if ((state_q == S_IDLE) && in_valid_i && !req_ignored &&
                 (in_data_i.command == bfa_pkg::CMD_FREE) && !list_full) begin
      ctl.op         = bfa_pkg::OP_PUSH;
      ctl.head.valid = 1'b1;
      ctl.head.base  = page_m;
      ctl.head.size  = bfa_pkg::PAGE_W'(in_data_i.page_count);
    end else if ((state_q == S_APPLY) && best_end.found) begin
      if (best_end.size == bfa_pkg::PAGE_W'(cnt_q)) begin
        ctl.op = bfa_pkg::OP_REMOVE;
      end else begin
        ctl.op = bfa_pkg::OP_SPLIT;
      end
    end
  end

  // row of list cells
  for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
    bfa_pkg::bfa_chunk_t left_w, right_w;
    bfa_pkg::bfa_best_t  best_in_w;
    logic [IdxW-1:0]     best_idx_in_w;

    if (i == 0) begin : g_head
      assign left_w        = ctl.head;
      assign best_in_w     = '0;
      assign best_idx_in_w = '0;
    end else begin : g_mid
      assign left_w        = chunk_w[i-1];
      assign best_in_w     = best_w[i-1];
      assign best_idx_in_w = best_idx_w[i-1];
    end

    if (i == MAX_CHUNKS - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_next
      assign right_w = chunk_w[i+1];
    end

    bfa_cell #(
      .IDX_W            (IdxW),
      .CELL_IDX         (i),
      .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .pick_i     (best_idx_end),
      .left_i     (left_w),
      .right_i    (right_w),
      .chunk_o    (chunk_w[i]),
      .best_i     (best_in_w),
      .best_idx_i (best_idx_in_w),
      .best_o     (best_w[i]),
      .best_idx_o (best_idx_w[i])
    );
  end

  // sequencer, free total, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_cnt_q   <= '0;
      cnt_q        <= '0;
      status_q     <= bfa_pkg::ST_DONE;
      granted_q    <= '0;
      pages_free_q <= '0;
      pool_base_q  <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        if (cfg_idx_i == bfa_pkg::REG_POOL_BASE) begin
          pool_base_q <= cfg_wdata_i & PageMask;
        end else begin
          pages_free_q <= FreeW'(cfg_wdata_i);
        end
      end

      // output transaction taken, unless the next result replaces it
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (req_ignored) begin
              status_q  <= bfa_pkg::ST_IGNORED;
              granted_q <= '0;
              state_q   <= S_DONE;
            end else if (in_data_i.command == bfa_pkg::CMD_FREE) begin
              granted_q <= '0;
              if (list_full) begin
                status_q <= bfa_pkg::ST_FULL;
              end else begin
                status_q     <= bfa_pkg::ST_DONE;
                pages_free_q <= pages_free_q + FreeW'(in_data_i.page_count);
              end
              state_q <= S_DONE;
            end else begin
              cnt_q      <= in_data_i.page_count;
              scan_cnt_q <= '0;
              state_q    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // wait while the token runs down the row to the tail
          if (scan_cnt_q == IdxW'(MAX_CHUNKS - 1)) begin
            state_q <= S_APPLY;
          end else begin
            scan_cnt_q <= scan_cnt_q + IdxW'(1);
          end
        end
        S_APPLY: begin
          if (best_end.found) begin
            status_q     <= bfa_pkg::ST_DONE;
            granted_q    <= best_end.base;
            pages_free_q <= pages_free_q - FreeW'(cnt_q);
          end else begin
            status_q  <= bfa_pkg::ST_NOFIT;
            granted_q <= '0;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q             <= 1'b1;
            out_data_q.status       <= status_q;
            out_data_q.granted_page <= granted_q;
            out_data_q.free_total   <= pages_free_q[FreeW-1] ? '1 :
                                       pages_free_q[bfa_pkg::TOTAL_W-1:0];
            state_q                 <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sim/bfa_checker.sv -----
// bfa_checker: watches the request, result and register ports of the allocator,
// keeps its own copy of the free chunk list and compares every result in order
// depends on bfa_pkg
`timescale 1ns / 100ps

module bfa_checker #(
  parameter int unsigned MAX_CHUNKS       = bfa_pkg::MAX_CHUNKS_DEF,
  parameter int unsigned PAGE_NUMBER_BITS = bfa_pkg::PAGE_NUMBER_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  bfa_pkg::bfa_in_t            in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  bfa_pkg::bfa_out_t           out_data_i,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [bfa_pkg::PAGE_W-1:0]  cfg_wdata_i,
  output int unsigned                 pending_o,
  output int unsigned                 fail_count_o
);

  // implemented page number bits
  localparam logic [bfa_pkg::PAGE_W-1:0] PAGE_BITS_MASK =
      (PAGE_NUMBER_BITS >= bfa_pkg::PAGE_W) ? '1 :
      ((bfa_pkg::PAGE_W'(1) << PAGE_NUMBER_BITS) - bfa_pkg::PAGE_W'(1));
  localparam logic [63:0] TOTAL_SAT =
      {{(64-bfa_pkg::TOTAL_W){1'b0}}, {bfa_pkg::TOTAL_W{1'b1}}};

  // shadow free list, kept in list order
  logic [bfa_pkg::PAGE_W-1:0] chunk_start [MAX_CHUNKS];
  logic [bfa_pkg::PAGE_W-1:0] chunk_pages [MAX_CHUNKS];
  int unsigned                chunks_listed;
  logic [63:0]                pages_available;
  logic [bfa_pkg::PAGE_W-1:0] pool_start;
  logic [bfa_pkg::PAGE_W-1:0] pool_pages;

  // results still owed by the block, oldest first
  bfa_pkg::bfa_out_t          owed_results[$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  // rebuild the list from the pool registers
  function automatic void reload_pool();
    int i;
    for (i = 0; i < MAX_CHUNKS; i++) begin
      chunk_start[i] = '0;
      chunk_pages[i] = '0;
    end
    if (pool_pages != '0) begin
      chunk_start[0] = pool_start;
      chunk_pages[0] = pool_pages;
      chunks_listed  = 1;
    end else begin
      chunks_listed  = 0;
    end
    pages_available = 64'(pool_pages);
  endfunction

  function automatic void write_register(input logic [0:0] idx,
                                         input logic [bfa_pkg::PAGE_W-1:0] value);
    case (bfa_pkg::bfa_reg_e'(idx))
      bfa_pkg::REG_POOL_BASE: begin
        pool_start = value & PAGE_BITS_MASK;
      end
      bfa_pkg::REG_POOL_COUNT: begin
        pool_pages = value;
        reload_pool();
      end
      default: begin
      end
    endcase
  endfunction

  // best-fit allocate, push-at-head free; returns the result the block owes
  function automatic bfa_pkg::bfa_out_t serve_request(input bfa_pkg::bfa_in_t req);
    bfa_pkg::bfa_out_t          res;
    logic [bfa_pkg::PAGE_W-1:0] need;
    logic [bfa_pkg::PAGE_W-1:0] page;
    int                         i;
    int                         pick;
    bit                         found;
    res        = '0;
    res.status = bfa_pkg::ST_DONE;
    need       = bfa_pkg::PAGE_W'(req.page_count);
    page       = req.page_number & PAGE_BITS_MASK;
    found      = 1'b0;
    pick       = 0;
    if (req.page_count == '0 || (req.command == bfa_pkg::CMD_FREE && page == '0)) begin
      res.status = bfa_pkg::ST_IGNORED;
    end else if (req.command == bfa_pkg::CMD_ALLOC) begin
      // smallest chunk that fits, earliest on ties
      for (i = 0; i < chunks_listed; i++) begin
        if (chunk_pages[i] >= need && (!found || chunk_pages[i] < chunk_pages[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        res.status = bfa_pkg::ST_NOFIT;
      end else begin
        res.granted_page = chunk_start[pick];
        if (chunk_pages[pick] > need) begin
          // split in place, tail stays at the same position
          chunk_start[pick] = (chunk_start[pick] + need) & PAGE_BITS_MASK;
          chunk_pages[pick] = chunk_pages[pick] - need;
        end else begin
          // exact fit, later entries close up
          for (i = pick; i + 1 < chunks_listed; i++) begin
            chunk_start[i] = chunk_start[i+1];
            chunk_pages[i] = chunk_pages[i+1];
          end
          chunks_listed--;
          chunk_start[chunks_listed] = '0;
          chunk_pages[chunks_listed] = '0;
        end
        pages_available = pages_available - 64'(need);
      end
    end else if (chunks_listed >= MAX_CHUNKS) begin
      res.status = bfa_pkg::ST_FULL;
    end else begin
      // push at the head, no merging with neighbors
      for (i = chunks_listed; i > 0; i--) begin
        chunk_start[i] = chunk_start[i-1];
        chunk_pages[i] = chunk_pages[i-1];
      end
      chunk_start[0] = page;
      chunk_pages[0] = need;
      chunks_listed++;
      pages_available = pages_available + 64'(need);
    end
    res.free_total = (pages_available > TOTAL_SAT) ? '1 :
                     pages_available[bfa_pkg::TOTAL_W-1:0];
    return res;
  endfunction

  // sample all ports at the clock edge
  always @(posedge clk_i) begin
    bfa_pkg::bfa_out_t want;
    if (!rst_ni) begin
      pool_start = '0;
      pool_pages = '0;
      reload_pool();
      owed_results.delete();
    end else begin
      // result transaction against the oldest owed result
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data_i), 64'd0);
        end else begin
          want = owed_results.pop_front();
          if (out_data_i.status !== want.status)
            report_mismatch("status", 64'(out_data_i.status), 64'(want.status));
          if (out_data_i.granted_page !== want.granted_page)
            report_mismatch("granted_page", 64'(out_data_i.granted_page),
                            64'(want.granted_page));
          if (out_data_i.free_total !== want.free_total)
            report_mismatch("free_total", 64'(out_data_i.free_total), 64'(want.free_total));
        end
      end
      // request transaction
      if (in_valid_i && in_ready_i) begin
        owed_results.push_back(serve_request(in_data_i));
      end
      if (cfg_we_i) begin
        write_register(cfg_idx_i, cfg_wdata_i);
      end
    end
    pending_o <= owed_results.size();
  end

endmodule

// ----- sim/tb_best_fit_page_chunk_allocator.sv -----
// tb_best_fit_page_chunk_allocator: drives requests, pool settings and result
// back-pressure into the allocator and gives the verdict; depends on bfa_pkg,
// bfa_checker and best_fit_page_chunk_allocator
`timescale 1ns / 100ps

module tb_best_fit_page_chunk_allocator;

  localparam int unsigned MAX_CHUNKS       = 64;
  localparam int unsigned PAGE_NUMBER_BITS = 44;
  localparam int unsigned DRAIN_CYCLES     = MAX_CHUNKS + 8;
  localparam int unsigned HOLD_CYCLES      = 600;
  localparam int unsigned STALL_LIMIT      = 5000;
  localparam int unsigned PHASE_ITEMS      = 400;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       req_valid  = 1'b0;
  logic                       req_ready;
  bfa_pkg::bfa_in_t           req_data   = '0;
  logic                       rsp_valid;
  logic                       rsp_ready  = 1'b0;
  bfa_pkg::bfa_out_t          rsp_data;
  logic                       cfg_we     = 1'b0;
  logic [0:0]                 cfg_idx    = '0;
  logic [bfa_pkg::PAGE_W-1:0] cfg_wdata  = '0;
  int unsigned                pending;
  int unsigned                fail_count;

  // idle percentages of both sides and the long receiver hold-off request
  int unsigned        tx_idle_pct = 27;
  int unsigned        rx_idle_pct = 59;
  bit                 rx_hold_req = 1'b0;

  best_fit_page_chunk_allocator #(
    .MAX_CHUNKS       (MAX_CHUNKS),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_data_i   (req_data),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_data_o  (rsp_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  bfa_checker #(
    .MAX_CHUNKS       (MAX_CHUNKS),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_ready_i   (req_ready),
    .in_data_i    (req_data),
    .out_valid_i  (rsp_valid),
    .out_ready_i  (rsp_ready),
    .out_data_i   (rsp_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // 100 MHz clock
  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // end the run when no transaction moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_best_fit_page_chunk_allocator failed");
    $finish;
  end

  // offer one request and hold it until the block takes it
  task automatic send_request(input bfa_pkg::bfa_cmd_e cmd,
                              input logic [bfa_pkg::PAGE_W-1:0] page,
                              input logic [bfa_pkg::COUNT_W-1:0] count);
    bfa_pkg::bfa_in_t req;
    req.command     = cmd;
    req.page_number = page;
    req.page_count  = count;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    req_valid <= 1'b1;
    req_data  <= req;
    do @(posedge clk); while (!req_ready);
  endtask

  // mostly small counts so that splits and exact fits are common
  task automatic send_random(input int unsigned free_pct);
    logic [bfa_pkg::PAGE_W-1:0]  page;
    logic [bfa_pkg::COUNT_W-1:0] count;
    bfa_pkg::bfa_cmd_e           cmd;
    int unsigned                 pick;
    page = bfa_pkg::PAGE_W'({$urandom(), $urandom()});
    pick = $urandom_range(99);
    if (pick < 12)
      count = $urandom();
    else if (pick < 30)
      count = $urandom_range(4096, 1);
    else
      count = $urandom_range(16, 1);
    cmd  = ($urandom_range(99) < free_pct) ? bfa_pkg::CMD_FREE : bfa_pkg::CMD_ALLOC;
    // a few requests the block has to ignore
    pick = $urandom_range(99);
    if (pick < 3) begin
      count = '0;
    end else if (pick < 6) begin
      cmd  = bfa_pkg::CMD_FREE;
      page = '0;
    end else if (page == '0) begin
      page = bfa_pkg::PAGE_W'(1);
    end
    send_request(cmd, page, count);
  endtask

  // wait until every owed result is out and the block has gone quiet
  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bfa_pkg::bfa_reg_e idx,
                           input logic [bfa_pkg::PAGE_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_pool(input logic [bfa_pkg::PAGE_W-1:0] start,
                          input logic [bfa_pkg::PAGE_W-1:0] pages);
    settle();
    write_reg(bfa_pkg::REG_POOL_BASE, start);
    write_reg(bfa_pkg::REG_POOL_COUNT, pages);
  endtask

  // stimulus and verdict
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list straight out of reset
    send_request(bfa_pkg::CMD_ALLOC, '0, 32'd5);
    send_request(bfa_pkg::CMD_FREE, '0, 32'd7);

    // pool at page zero, ignored requests, exact fits at the field extremes
    set_pool('0, bfa_pkg::PAGE_W'(100));
    send_request(bfa_pkg::CMD_ALLOC, '0, 32'd10);
    send_request(bfa_pkg::CMD_ALLOC, bfa_pkg::PAGE_W'(55), '0);
    send_request(bfa_pkg::CMD_FREE, bfa_pkg::PAGE_W'(1000), '0);
    send_request(bfa_pkg::CMD_FREE, '1, '1);
    send_request(bfa_pkg::CMD_ALLOC, '0, '1);
    send_request(bfa_pkg::CMD_ALLOC, '0, 32'd90);
    send_request(bfa_pkg::CMD_ALLOC, '0, 32'd1);
    // same chunk freed twice, tie goes to the earliest entry
    send_request(bfa_pkg::CMD_FREE, bfa_pkg::PAGE_W'(5), 32'd3);
    send_request(bfa_pkg::CMD_FREE, bfa_pkg::PAGE_W'(5), 32'd3);
    send_request(bfa_pkg::CMD_ALLOC, '0, 32'd2);
    // best fit sits behind a larger chunk
    send_request(bfa_pkg::CMD_FREE, bfa_pkg::PAGE_W'(200), 32'd20);
    send_request(bfa_pkg::CMD_FREE, bfa_pkg::PAGE_W'(100), 32'd50);
    send_request(bfa_pkg::CMD_ALLOC, '0, 32'd15);

    // pool at the top of the page space: wrapping split and saturated total
    set_pool('1 - bfa_pkg::PAGE_W'(3), '1);
    send_request(bfa_pkg::CMD_ALLOC, '0, 32'd8);
    send_request(bfa_pkg::CMD_FREE, bfa_pkg::PAGE_W'(7), '1);
    send_request(bfa_pkg::CMD_ALLOC, '0, '1);
    send_request(bfa_pkg::CMD_FREE, 44'h800_0000_0001, 32'h8000_0000);
    send_request(bfa_pkg::CMD_ALLOC, '0, 32'h8000_0000);

    // zero count reloads an empty list
    set_pool(bfa_pkg::PAGE_W'(64), '0);
    send_request(bfa_pkg::CMD_ALLOC, '0, 32'd1);

    // balanced mix on a mid-sized pool
    set_pool(bfa_pkg::PAGE_W'({$urandom(), $urandom()}), bfa_pkg::PAGE_W'(5000));
    repeat (PHASE_ITEMS) send_random(50);

    // free-heavy mix fills the table; one long result stall on the way
    settle();
    tx_idle_pct = 59;
    rx_idle_pct = 27;
    set_pool('1, '1);
    repeat (PHASE_ITEMS / 2) send_random(85);
    rx_hold_req = 1'b1;
    repeat (PHASE_ITEMS / 2) send_random(85);

    // back to back from an empty list, then a random pool
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_pool('0, '0);
    repeat (PHASE_ITEMS) send_random(60);
    set_pool(bfa_pkg::PAGE_W'({$urandom(), $urandom()}),
             bfa_pkg::PAGE_W'({$urandom(), $urandom()}));
    repeat (PHASE_ITEMS) send_random(40);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_best_fit_page_chunk_allocator passed");
    end else begin
      $display("tb_best_fit_page_chunk_allocator failed");
    end
    $finish;
  end

endmodule
